[rtl/spr_pkg.sv]
// Shared types and constants of the systematic particle resampler.
`default_nettype none
package spr_pkg;

  localparam int WEIGHT_W = 16;
  localparam int OFFSET_W = 16;
  localparam int INDEX_W  = 6;

  typedef struct packed {
    logic load;
    logic init_rd;
    logic prep;
    logic advance;
    logic emit;
    logic finish;
  } spr_cmd_t;

  typedef struct packed {
    logic adv_ok;
    logic last_k;
  } spr_status_t;

endpackage
`default_nettype wire

[rtl/spr_datapath.sv]
// Datapath of the resampler: weight store, running total and the cross-multiplied draw compare.
`default_nettype none
module spr_datapath import spr_pkg::*; #(
  parameter int MAX_PARTICLES = 64,
  parameter int WEIGHT_BITS   = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire spr_cmd_t            cmd_i,
  input  wire logic [WEIGHT_W-1:0] weight_i,
  input  wire logic [OFFSET_W-1:0] offset_i,
  output spr_status_t              st_o,
  output logic [INDEX_W-1:0]       source_index_o,
  output logic                     last_of_run_o
);

  localparam int SW   = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam int IW   = $clog2(MAX_PARTICLES);
  localparam int CW   = $clog2(MAX_PARTICLES + 1);
  localparam int TW   = SW + IW;
  localparam int LW   = TW + CW;
  localparam int CMPW = LW + OFFSET_W;

  logic [SW-1:0]       mem_q [MAX_PARTICLES];
  logic [SW-1:0]       rd_q;
  logic [IW-1:0]       rd_addr;
  logic [CW-1:0]       count_q, count_d;
  logic [TW-1:0]       total_q, total_d;
  logic [OFFSET_W-1:0] offset_q;
  logic [IW-1:0]       idx_q;
  logic [IW-1:0]       k_q;
  logic [LW-1:0]       lhs_q;
  logic [CMPW-1:0]     rhs_q;
  logic [IW-1:0]       src_q;
  logic                last_q;
  logic [SW-1:0]       w;
  logic                full;
  logic [SW+CW-1:0]    wn;
  logic [OFFSET_W+TW-1:0] rhs0;
  logic [CMPW-1:0]     step;
  logic                total_zero;

  assign w          = weight_i[SW-1:0];
  assign full       = (count_q == CW'(MAX_PARTICLES));
  assign rd_addr    = cmd_i.init_rd ? '0 : idx_q + IW'(1);
  assign wn         = rd_q * count_q;
  assign rhs0       = offset_q * total_q;
  assign step       = CMPW'({total_q, {OFFSET_W{1'b0}}});
  assign total_zero = (total_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem_q[count_q[IW-1:0]] <= w;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    count_d = count_q;
    total_d = total_q;
    if (cmd_i.finish) begin
      count_d = '0;
      total_d = '0;
    end else if (cmd_i.load && !full) begin
      count_d = count_q + CW'(1);
      total_d = total_q + TW'(w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
    end else begin
      count_q <= count_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      offset_q <= offset_i;
    end
    if (cmd_i.prep) begin
      lhs_q <= LW'(wn);
      rhs_q <= CMPW'(rhs0);
      idx_q <= '0;
      k_q   <= '0;
    end else if (cmd_i.advance) begin
      lhs_q <= lhs_q + LW'(wn);
      idx_q <= idx_q + IW'(1);
    end else if (cmd_i.emit) begin
      src_q  <= total_zero ? k_q : idx_q;
      last_q <= st_o.last_k;
      k_q    <= k_q + IW'(1);
      rhs_q  <= rhs_q + step;
    end
  end

  assign st_o.last_k = ((CW'(k_q) + CW'(1)) == count_q);
  assign st_o.adv_ok = !total_zero
                    && ({lhs_q, {OFFSET_W{1'b0}}} <= rhs_q)
                    && ((CW'(idx_q) + CW'(1)) < count_q);

  assign source_index_o = INDEX_W'(src_q);
  assign last_of_run_o  = last_q;

endmodule
`default_nettype wire

[rtl/spr_controller.sv]
// Controller of the resampler: load, draw setup, index walk and result handoff.
`default_nettype none
module spr_controller import spr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        last_weight_i,
  output logic             in_stall_o,
  input  wire logic        out_stall_i,
  output logic             out_valid_o,
  input  wire spr_status_t st_i,
  output spr_cmd_t         cmd_o
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_ADV  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_weight_i) begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        cmd_o.init_rd = 1'b1;
        state_d       = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_CMP;
      end
      S_CMP: begin
        priority if (st_i.adv_ok) begin
          state_d = S_ADV;
        end else if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          if (st_i.last_k) begin
            cmd_o.finish = 1'b1;
            state_d      = S_LOAD;
          end
        end
      end
      S_ADV: begin
        cmd_o.advance = 1'b1;
        state_d       = S_CMP;
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_LOAD);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

[rtl/systematic_particle_resampler.sv]
// Top level of the systematic particle resampler.
// Load: one weight item per cycle while the input is not stalled; the last item ends the set.
// Draw: a read state and a prep state set up the draw, then each compare either emits an
//   index or steps the store index through an advance state; the store has one read port.
// The read and prep states follow the last item; a stalled result holds emits, not advances.
// Reset clears the particle count, the total and the handshake state; the store is not cleared.
`default_nettype none
module systematic_particle_resampler import spr_pkg::*; #(
  parameter int MAX_PARTICLES = 64,
  parameter int WEIGHT_BITS   = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [WEIGHT_W-1:0] weight_i,
  input  wire logic                last_weight_i,
  input  wire logic [OFFSET_W-1:0] offset_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [INDEX_W-1:0]       source_index_o,
  output logic                     last_of_run_o
);

  spr_cmd_t    cmd;
  spr_status_t st;

  spr_controller u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .last_weight_i (last_weight_i),
    .in_stall_o    (in_stall_o),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .st_i          (st),
    .cmd_o         (cmd)
  );

  spr_datapath #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .WEIGHT_BITS   (WEIGHT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .weight_i       (weight_i),
    .offset_i       (offset_i),
    .st_o           (st),
    .source_index_o (source_index_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule
`default_nettype wire

[rtl/spr_checker.sv]
// Port-level assertions of the resampler and their bind to the top level.
`default_nettype none
module spr_checker import spr_pkg::*; #(
  parameter int MAX_PARTICLES = 64
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                last_weight_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [INDEX_W-1:0]  source_index_o,
  input wire logic                last_of_run_o
);

  a_draw_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_weight_i) |=> in_stall_o)
    else $error("input not stalled after the last item");

  a_draw_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> (out_valid_o && last_of_run_o))
    else $error("load resumed without a final result");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(source_index_o) < MAX_PARTICLES))
    else $error("source index beyond the store");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(source_index_o) && $stable(last_of_run_o)))
    else $error("stalled result changed");

endmodule

bind systematic_particle_resampler spr_checker #(
  .MAX_PARTICLES (MAX_PARTICLES)
) u_spr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .last_weight_i  (last_weight_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .source_index_o (source_index_o),
  .last_of_run_o  (last_of_run_o)
);
`default_nettype wire
